@@ design/atrp_pkg.sv @@
// Package for the accelerometer tilt core: widths, payload structs,
// register indexes and the CORDIC arctangent table. No dependencies.
package atrp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int PRE_SHIFT           = 14;
    localparam int TAB_LEN             = 24;
    localparam logic [30:0] GAIN_Q30   = 31'd1768195363;

    // CORDIC datapath widths
    localparam int XW  = 36;
    localparam int ZW  = 26;
    localparam int NKW = 32;

    // configuration register indexes
    localparam logic REG_SWAP_ALL   = 1'b0;
    localparam logic REG_SWAP_THUMB = 1'b1;

    typedef logic signed [XW-1:0]  t_xy;
    typedef logic signed [ZW-1:0]  t_ang;
    typedef logic signed [NKW-1:0] t_nk;

    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_ang z;
    } t_lane;

    typedef struct packed {
        logic thumb;
        logic swapped;
        logic zero_all;
        logic roll_dz;
        logic pitch_dz;
        t_nk  roll_nk;
        t_nk  pitch_nk;
    } t_side;

    // atan(2^-i) in degrees * 2^16
    function automatic t_ang atan_q16(input int idx);
        t_ang v;
        case (idx)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/atrp_if.sv @@
// Channel interfaces for the tilt core: sample in, angles out, config writes.
// Depends on nothing.
interface atrp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [2:0]         finger;
    modport source (output valid, accel_x, accel_y, accel_z, finger, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, finger, output ready);
endinterface

interface atrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    modport source (output valid, roll, pitch, input ready);
    modport sink   (input valid, roll, pitch, output ready);
endinterface

interface atrp_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/atrp_cell.sv @@
// One CORDIC vectoring cell: a micro-rotation of the roll and pitch lanes.
// Uses atrp_pkg; the sideband of the beat rides along unchanged.
module atrp_cell #(
    parameter int STEP  = 0,
    parameter bit ANGLE = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  atrp_pkg::t_lane i_roll,
    input  atrp_pkg::t_lane i_pitch,
    input  atrp_pkg::t_side i_side,
    output logic            o_valid,
    output atrp_pkg::t_lane o_roll,
    output atrp_pkg::t_lane o_pitch,
    output atrp_pkg::t_side o_side
);

    localparam atrp_pkg::t_ang STEP_ANG = ANGLE ? atrp_pkg::atan_q16(STEP) : '0;

    function automatic atrp_pkg::t_lane rotate(input atrp_pkg::t_lane l);
        atrp_pkg::t_lane r;
        atrp_pkg::t_xy   xs;
        atrp_pkg::t_xy   ys;
        xs = l.x >>> STEP;
        ys = l.y >>> STEP;
        if (!l.y[atrp_pkg::XW-1]) begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + STEP_ANG;
        end else begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - STEP_ANG;
        end
        return r;
    endfunction

    logic            r_valid;
    atrp_pkg::t_lane r_roll;
    atrp_pkg::t_lane r_pitch;
    atrp_pkg::t_side r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_roll  <= rotate(i_roll);
            r_pitch <= rotate(i_pitch);
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;
    assign o_side  = r_side;

endmodule

@@ design/accel_tilt_roll_pitch_core.sv @@
// Top level of the accelerometer tilt core: input stage, magnitude and
// arctangent cell rows, rounding/saturation, output register with skid.
//
//   channel  | role          | beat
//   ---------+---------------+--------------------------------------------
//   i_in     | sink          | accel_x, accel_y, accel_z, finger
//   o_out    | source        | roll, pitch
//   i_cfg    | sink          | index, data (swap_all, swap_thumb)
//
// One sample per cycle while the output does not stall; the path runs through the
// input register, two rows of CORDIC_STEPS cells and the output register.
// Reset (i_rst_n low, synchronous) clears valids and both config bits.
// Output stall: the skid register catches the beat in flight, then the
// whole row holds until the skid drains. Config writes are always taken.
module accel_tilt_roll_pitch_core #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = atrp_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atrp_in_if.sink     i_in,
    atrp_out_if.source  o_out,
    atrp_cfg_if.sink    i_cfg
);

    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int FW = 28;
    localparam logic signed [FW-1:0] HALF    = FW'(1) <<< (SH - 1);
    localparam logic signed [FW-1:0] LIM_R   = FW'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [FW-1:0] LIM_P   = FW'(90) <<< ANGLE_FRAC_BITS;

    // ---------------- configuration
    logic r_swap_all;
    logic r_swap_thumb;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_all   <= 1'b0;
            r_swap_thumb <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                atrp_pkg::REG_SWAP_ALL:   r_swap_all   <= i_cfg.data;
                atrp_pkg::REG_SWAP_THUMB: r_swap_thumb <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control
    logic en;
    logic r_skid_v;
    assign en         = !r_skid_v;
    assign i_in.ready = en;

    // ---------------- input stage
    logic               r_s0_v;
    logic signed [15:0] r_s0_x;
    logic signed [15:0] r_s0_y;
    logic signed [15:0] r_s0_z;
    logic               r_s0_thumb;
    logic               r_s0_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x     <= i_in.accel_x;
            r_s0_y     <= i_in.accel_y;
            r_s0_z     <= i_in.accel_z;
            r_s0_thumb <= (i_in.finger == 3'd0);
            r_s0_sw    <= r_swap_all || (r_swap_thumb && (i_in.finger == 3'd0));
        end
    end

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic atrp_pkg::t_xy pre(input logic signed [15:0] v);
        return atrp_pkg::t_xy'({mag17(v), 14'b0});
    endfunction

    // |num| * 2^14 * gain >> 30, sign restored
    function automatic atrp_pkg::t_nk scale(input logic signed [15:0] v);
        logic [47:0]   p;
        atrp_pkg::t_nk m;
        p = mag17(v) * atrp_pkg::GAIN_Q30;
        m = atrp_pkg::t_nk'(p[47:16]);
        return v[15] ? -m : m;
    endfunction

    logic signed [15:0] roll_num;
    logic signed [15:0] roll_a;
    logic signed [15:0] pitch_num;
    logic signed [15:0] pitch_a;
    atrp_pkg::t_side    side0;
    atrp_pkg::t_lane    roll0;
    atrp_pkg::t_lane    pitch0;

    always_comb begin
        roll_num  = r_s0_sw ? r_s0_x : r_s0_y;
        roll_a    = r_s0_sw ? r_s0_y : r_s0_x;
        pitch_num = r_s0_sw ? r_s0_y : r_s0_x;
        pitch_a   = r_s0_sw ? r_s0_x : r_s0_y;

        side0.thumb    = r_s0_thumb;
        side0.swapped  = r_s0_sw;
        side0.zero_all = (r_s0_x == 16'sd0) && (r_s0_y == 16'sd0) && (r_s0_z == 16'sd0);
        side0.roll_dz  = (roll_a == 16'sd0) && (r_s0_z == 16'sd0);
        side0.pitch_dz = (pitch_a == 16'sd0) && (r_s0_z == 16'sd0);
        side0.roll_nk  = scale(roll_num);
        side0.pitch_nk = scale(pitch_num);

        roll0.x  = pre(roll_a);
        roll0.y  = pre(r_s0_z);
        roll0.z  = '0;
        pitch0.x = pre(pitch_a);
        pitch0.y = pre(r_s0_z);
        pitch0.z = '0;
    end

    // ---------------- cell rows: magnitude then arctangent
    logic            v_m [0:CORDIC_STEPS];
    atrp_pkg::t_lane r_m [0:CORDIC_STEPS];
    atrp_pkg::t_lane p_m [0:CORDIC_STEPS];
    atrp_pkg::t_side s_m [0:CORDIC_STEPS];
    logic            v_a [0:CORDIC_STEPS];
    atrp_pkg::t_lane r_a [0:CORDIC_STEPS];
    atrp_pkg::t_lane p_a [0:CORDIC_STEPS];
    atrp_pkg::t_side s_a [0:CORDIC_STEPS];

    assign v_m[0] = r_s0_v;
    assign r_m[0] = roll0;
    assign p_m[0] = pitch0;
    assign s_m[0] = side0;

    // arctangent starts from (gain*|(a,b)|, gain*num)
    assign v_a[0]   = v_m[CORDIC_STEPS];
    assign s_a[0]   = s_m[CORDIC_STEPS];
    assign r_a[0].x = r_m[CORDIC_STEPS].x;
    assign r_a[0].y = atrp_pkg::t_xy'(s_m[CORDIC_STEPS].roll_nk);
    assign r_a[0].z = '0;
    assign p_a[0].x = p_m[CORDIC_STEPS].x;
    assign p_a[0].y = atrp_pkg::t_xy'(s_m[CORDIC_STEPS].pitch_nk);
    assign p_a[0].z = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_row
        atrp_cell #(.STEP(k), .ANGLE(1'b0)) u_mag (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_m[k]),
            .i_roll  (r_m[k]),
            .i_pitch (p_m[k]),
            .i_side  (s_m[k]),
            .o_valid (v_m[k+1]),
            .o_roll  (r_m[k+1]),
            .o_pitch (p_m[k+1]),
            .o_side  (s_m[k+1])
        );
        atrp_cell #(.STEP(k), .ANGLE(1'b1)) u_ang (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_a[k]),
            .i_roll  (r_a[k]),
            .i_pitch (p_a[k]),
            .i_side  (s_a[k]),
            .o_valid (v_a[k+1]),
            .o_roll  (r_a[k+1]),
            .o_pitch (p_a[k+1]),
            .o_side  (s_a[k+1])
        );
    end

    // ---------------- thumb fix, rounding, saturation
    atrp_pkg::t_side    sf;
    logic signed [FW-1:0] zr;
    logic signed [FW-1:0] zp;
    logic signed [FW-1:0] rr;
    logic signed [FW-1:0] rp;
    logic signed [15:0] fin_roll;
    logic signed [14:0] fin_pitch;

    always_comb begin
        sf = s_a[CORDIC_STEPS];
        zr = (sf.zero_all || sf.roll_dz)  ? '0 : FW'(r_a[CORDIC_STEPS].z);
        zp = (sf.zero_all || sf.pitch_dz) ? '0 : FW'(p_a[CORDIC_STEPS].z);
        if (sf.swapped && sf.thumb) begin
            zr = -zr;
            zp = zp <<< 1;
        end
        rr = (zr + HALF) >>> SH;
        rp = (zp + HALF) >>> SH;
        if (rr > LIM_R)  rr = LIM_R;
        if (rr < -LIM_R) rr = -LIM_R;
        if (rp > LIM_P)  rp = LIM_P;
        if (rp < -LIM_P) rp = -LIM_P;
        fin_roll  = rr[15:0];
        fin_pitch = rp[14:0];
    end

    // ---------------- output register and skid
    logic               beat_in;
    logic               r_out_v;
    logic signed [15:0] r_out_roll;
    logic signed [14:0] r_out_pitch;
    logic signed [15:0] r_skid_roll;
    logic signed [14:0] r_skid_pitch;

    assign beat_in = v_a[CORDIC_STEPS] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            r_out_v  <= r_skid_v || beat_in;
            r_skid_v <= 1'b0;
        end else if (beat_in) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            r_out_roll  <= r_skid_v ? r_skid_roll  : fin_roll;
            r_out_pitch <= r_skid_v ? r_skid_pitch : fin_pitch;
        end else if (beat_in) begin
            r_skid_roll  <= fin_roll;
            r_skid_pitch <= fin_pitch;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.roll  = r_out_roll;
    assign o_out.pitch = r_out_pitch;

endmodule

@@ design/atrp_checker.sv @@
// Port-level checks for the tilt core, bound to accel_tilt_roll_pitch_core.
// Depends on atrp_pkg for the default fraction width.
module atrp_checker #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_roll,
    input logic signed [14:0] i_pitch,
    input logic               i_cfg_ready
);

    localparam int LIM_R = 180 << ANGLE_FRAC_BITS;
    localparam int LIM_P = 90 << ANGLE_FRAC_BITS;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_roll) && $stable(i_pitch))
        else $error("stalled result beat changed");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (LIM_R > 32767) || (int'(i_roll) <= LIM_R && int'(i_roll) >= -LIM_R))
        else $error("roll beyond saturation limit");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (LIM_P > 16383) || (int'(i_pitch) <= LIM_P && int'(i_pitch) >= -LIM_P))
        else $error("pitch beyond saturation limit");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind accel_tilt_roll_pitch_core atrp_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll      (o_out.roll),
    .i_pitch     (o_out.pitch),
    .i_cfg_ready (i_cfg.ready)
);

@@ tb/sv/tb_accel_tilt_roll_pitch_core.sv @@
// Testbench for accel_tilt_roll_pitch_core: drives samples and register writes,
// predicts roll and pitch with a bit-exact CORDIC model and checks every beat.
// Depends on atrp_pkg and the channel interfaces in design/atrp_if.sv.
`timescale 1ns / 100ps

module tb_accel_tilt_roll_pitch_core;

    localparam int FRAC  = 7;
    localparam int STEPS = 16;
    localparam int LAT   = 2 * STEPS + 2;
    localparam longint LIMIT = 2_000_000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [2:0]         finger;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    atrp_in_if  in_ch ();
    atrp_out_if out_ch ();
    atrp_cfg_if cfg_ch ();

    accel_tilt_roll_pitch_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    t_sample sample_q[$];
    t_angles angles_q[$];
    logic    pred_swap_all = 1'b0;
    logic    pred_swap_thumb = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      errors = 0;
    longint  cycles = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
        return (i < 24) ? t[i] : 0;
    endfunction

    // atan2(num, |(a,b)|) in degrees * 2^16
    function automatic longint tilt_q16(longint num, longint a, longint b);
        longint x, y, z, xs, ys, nk;
        if (a == 0 && b == 0) return 0;
        x = labs(a) << 14;
        y = labs(b) << 14;
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i); ys = asr(y, i);
            if (y >= 0) begin x += ys; y -= xs; end
            else begin x -= ys; y += xs; end
        end
        nk = ((labs(num) << 14) * 64'sd1768195363) >>> 30;
        if (num < 0) nk = -nk;
        y = nk; z = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i); ys = asr(y, i);
            if (y >= 0) begin x += ys; y -= xs; z += atan_entry(i); end
            else begin x -= ys; y += xs; z -= atan_entry(i); end
        end
        return z;
    endfunction

    function automatic longint round_sat(longint z, longint lim_deg);
        longint r, lim;
        r = asr(z + (64'sd1 << (15 - FRAC)), 16 - FRAC);
        lim = lim_deg << FRAC;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles predict_angles(t_sample s);
        longint x, y, z, roll, pitch;
        logic thumb, swapped;
        t_angles a;
        x = s.x; y = s.y; z = s.z;
        thumb = (s.finger == 3'd0);
        swapped = pred_swap_all || (pred_swap_thumb && thumb);
        if (x == 0 && y == 0 && z == 0) begin
            roll = 0; pitch = 0;
        end else if (swapped) begin
            roll = tilt_q16(x, y, z);
            pitch = tilt_q16(y, x, z);
            if (thumb) begin
                roll = -roll;
                pitch = pitch * 2;
            end
        end else begin
            roll = tilt_q16(y, x, z);
            pitch = tilt_q16(x, y, z);
        end
        a.roll = 16'(round_sat(roll, 180));
        a.pitch = 15'(round_sat(pitch, 90));
        return a;
    endfunction

    // driver: present the head of the sample queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                angles_q.push_back(predict_angles(sample_q.pop_front()));
            end
            if ((!in_ch.valid || in_ch.ready) && sample_q.size() > 0 &&
                    ($urandom_range(99) >= send_idle_pct)) begin
                in_ch.valid   <= 1'b1;
                in_ch.accel_x <= sample_q[0].x;
                in_ch.accel_y <= sample_q[0].y;
                in_ch.accel_z <= sample_q[0].z;
                in_ch.finger  <= sample_q[0].finger;
            end else if (in_ch.ready) begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_angles exp_a;
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angles_q.size() == 0) begin
                $display("%0t: unexpected beat roll=%0d pitch=%0d", $time,
                         out_ch.roll, out_ch.pitch);
                errors++;
            end else begin
                exp_a = angles_q.pop_front();
                if (exp_a.roll !== out_ch.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time,
                             exp_a.roll, out_ch.roll);
                    errors++;
                end
                if (exp_a.pitch !== out_ch.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time,
                             exp_a.pitch, out_ch.pitch);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == atrp_pkg::REG_SWAP_ALL) pred_swap_all = val;
        else pred_swap_thumb = val;
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || in_ch.valid || angles_q.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        t_sample s;
        repeat (n) begin
            s.x = rand_axis(); s.y = rand_axis(); s.z = rand_axis();
            if ($urandom_range(19) == 0) begin s.x = 0; s.y = 0; s.z = 0; end
            else if ($urandom_range(9) == 0) begin s.x = 0; s.z = 0; end
            else if ($urandom_range(9) == 0) begin s.y = 0; s.z = 0; end
            s.finger = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                : 3'($urandom_range(4));
            sample_q.push_back(s);
        end
    endtask

    initial begin
        t_sample d[$];
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
        in_ch.finger = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = atrp_pkg::REG_SWAP_ALL; cfg_ch.data = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: zero vector, zero denominators, extreme axes
        d = '{'{16'sd0, 16'sd0, 16'sd0, 3'd0}, '{16'sh7fff, 16'sd0, 16'sd0, 3'd1},
              '{16'sh8000, 16'sd0, 16'sd0, 3'd0}, '{16'sd0, 16'sh7fff, 16'sd0, 3'd0},
              '{16'sd0, 16'sh8000, 16'sd0, 3'd2}, '{16'sd0, 16'sd0, 16'sh8000, 3'd3},
              '{16'sh7fff, 16'sh7fff, 16'sh7fff, 3'd4},
              '{16'sh8000, 16'sh8000, 16'sh8000, 3'd7},
              '{16'sd1, 16'sd0, 16'sd0, 3'd5}, '{16'sd0, -16'sd1, 16'sd0, 3'd0},
              '{16'sd1, -16'sd1, 16'sd1, 3'd6}, '{16'sh7fff, 16'sh8000, 16'sd1, 3'd0}};
        for (int c = 0; c < 4; c++) begin
            write_reg(atrp_pkg::REG_SWAP_ALL, c[0]);
            write_reg(atrp_pkg::REG_SWAP_THUMB, c[1]);
            foreach (d[i]) sample_q.push_back(d[i]);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(atrp_pkg::REG_SWAP_ALL, logic'($urandom_range(1)));
            write_reg(atrp_pkg::REG_SWAP_THUMB, logic'(ph[0]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            queue_random(125);
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
